// ===== sv/bcc_pkg.sv =====
// Shared constants, codes and the mnemonic table for the reply frame parser.
package bcc_pkg;

  localparam int unsigned MANT_W   = 21;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PLACES_W = 3;
  localparam int unsigned MNEM_CNT = 21;

  typedef logic [7:0]          byte_t;
  typedef logic [15:0]         mnem_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam byte_t CH_STX   = 8'h02;
  localparam byte_t CH_ETX   = 8'h03;
  localparam byte_t CH_ACK   = 8'h06;
  localparam byte_t CH_NAK   = 8'h15;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t CH_NINE  = 8'h39;
  localparam byte_t CH_POINT = 8'h2E;
  localparam byte_t CH_MINUS = 8'h2D;
  localparam byte_t CH_PLUS  = 8'h2B;
  localparam byte_t CH_SPACE = 8'h20;

  localparam status_t ST_VALUE     = 3'd0;
  localparam status_t ST_MISMATCH  = 3'd1;
  localparam status_t ST_ACK       = 3'd2;
  localparam status_t ST_NAK       = 3'd3;
  localparam status_t ST_MALFORMED = 3'd4;

  localparam idx_t IDX_UNKNOWN = 5'd21;

  // Two letters per entry, first letter in the high byte.
  localparam mnem_t MNEM_TABLE [MNEM_CNT] = '{
    "OP", "PV", "A1", "A2", "HA", "LA", "DA",
    "BP", "CC", "CH", "HO", "HS", "LS", "RG",
    "SL", "SP", "TD", "TI", "XP", "HB", "LB"
  };

endpackage

// ===== sv/bcc_ifs.sv =====
// Valid/ready channel interfaces for the byte input and the parsed result.
interface bcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bcc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [4:0]         param_index;
  logic signed [20:0] value_mantissa;
  logic [2:0]         decimal_places;

  modport source (output valid, output status, output param_index,
                  output value_mantissa, output decimal_places, input ready);
  modport sink   (input valid, input status, input param_index,
                  input value_mantissa, input decimal_places, output ready);
endinterface

// ===== sv/bcc_reply_frame_parser.sv =====
// Top level: byte-serial reply frame parser with block check and value decode.
// A result appears on the output register in the cycle after the byte
// that completes it (check byte, ACK or NAK) is accepted.
// Throughput: one byte per cycle; the whole frame state updates in the accept
// cycle and a held result stalls input only while the output register is full
// and not being taken.
// Reset: synchronous active-low rst_n returns to hunting for STX, clears state.
module bcc_reply_frame_parser
  import bcc_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 6
) (
  input  logic         clk,
  input  logic         rst_n,
  bcc_in_if.sink       in_ch,
  bcc_out_if.source    out_ch
);

  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_MN1   = 3'd1;
  localparam logic [2:0] PH_MN2   = 3'd2;
  localparam logic [2:0] PH_VALUE = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;

  logic [2:0]        phase_r,  phase_nxt;
  byte_t             bcc_r,    bcc_nxt;
  mnem_t             mnem_r,   mnem_nxt;
  logic [MANT_W-1:0] mant_r,   mant_nxt;
  logic [CNT_W-1:0]  dig_r,    dig_nxt;
  logic [CNT_W-1:0]  plc_r,    plc_nxt;
  logic              point_r,  point_nxt;
  logic              neg_r,    neg_nxt;
  logic              bad_r,    bad_nxt;
  logic              lead_r,   lead_nxt;

  logic                     out_valid_r;
  status_t                  out_status_r;
  idx_t                     out_idx_r;
  logic [MANT_W-1:0]        out_mant_r;
  logic [PLACES_W-1:0]      out_plc_r;

  logic                load;
  logic                accept;
  byte_t               c;
  idx_t                mnem_idx;
  logic                res_valid;
  status_t             res_status;
  idx_t                res_idx;
  logic [MANT_W-1:0]   res_mant;
  logic [PLACES_W-1:0] res_plc;

  bcc_mnem_lookup u_lookup (
    .mnem  (mnem_r),
    .index (mnem_idx)
  );

  assign load        = out_ch.ready || !out_valid_r;
  assign in_ch.ready = load;
  assign accept      = in_ch.valid && load;
  assign c           = in_ch.rx_byte;

  always_comb begin
    phase_nxt  = phase_r;
    bcc_nxt    = bcc_r;
    mnem_nxt   = mnem_r;
    mant_nxt   = mant_r;
    dig_nxt    = dig_r;
    plc_nxt    = plc_r;
    point_nxt  = point_r;
    neg_nxt    = neg_r;
    bad_nxt    = bad_r;
    lead_nxt   = lead_r;
    res_valid  = 1'b0;
    res_status = ST_VALUE;
    res_idx    = IDX_UNKNOWN;
    res_mant   = '0;
    res_plc    = '0;

    if (accept) begin
      if (c == CH_STX && phase_r != PH_CHECK) begin
        // (Re)start a frame from any phase except the check byte.
        phase_nxt = PH_MN1;
        bcc_nxt   = '0;
        mnem_nxt  = '0;
        mant_nxt  = '0;
        dig_nxt   = '0;
        plc_nxt   = '0;
        point_nxt = 1'b0;
        neg_nxt   = 1'b0;
        bad_nxt   = 1'b0;
        lead_nxt  = 1'b0;
      end else begin
        unique case (phase_r)
          PH_MN1, PH_MN2: begin
            bcc_nxt = bcc_r ^ c;
            if (c == CH_ETX) begin
              bad_nxt   = 1'b1;
              phase_nxt = PH_CHECK;
            end else if (phase_r == PH_MN1) begin
              mnem_nxt  = {c, 8'h00};
              phase_nxt = PH_MN2;
            end else begin
              mnem_nxt  = {mnem_r[15:8], c};
              phase_nxt = PH_VALUE;
            end
          end
          PH_VALUE: begin
            bcc_nxt = bcc_r ^ c;
            if (c == CH_ETX) begin
              phase_nxt = PH_CHECK;
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
              lead_nxt = 1'b1;
              if (dig_r >= CNT_W'(MAX_DIGITS)) begin
                bad_nxt = 1'b1;
              end else begin
                mant_nxt = (mant_r << 3) + (mant_r << 1) + MANT_W'(c[3:0]);
                dig_nxt  = dig_r + 1'b1;
                if (point_r) begin
                  plc_nxt = plc_r + 1'b1;
                end
              end
            end else if (c == CH_POINT) begin
              if (point_r) begin
                bad_nxt = 1'b1;
              end
              point_nxt = 1'b1;
              lead_nxt  = 1'b1;
            end else if (c == CH_MINUS || c == CH_PLUS) begin
              if (lead_r) begin
                bad_nxt = 1'b1;
              end else if (c == CH_MINUS) begin
                neg_nxt = 1'b1;
              end
              lead_nxt = 1'b1;
            end else if (c == CH_SPACE && !lead_r) begin
              // skip leading space
            end else begin
              bad_nxt = 1'b1;
            end
          end
          PH_CHECK: begin
            phase_nxt = PH_HUNT;
            res_valid = 1'b1;
            if (c != bcc_r) begin
              res_status = ST_MISMATCH;
            end else if (bad_r || dig_r == '0) begin
              res_status = ST_MALFORMED;
              res_idx    = mnem_idx;
            end else begin
              res_status = ST_VALUE;
              res_idx    = mnem_idx;
              res_mant   = neg_r ? (MANT_W'(0) - mant_r) : mant_r;
              res_plc    = PLACES_W'(plc_r);
            end
          end
          default: begin
            phase_nxt = PH_HUNT;
            if (c == CH_ACK) begin
              res_valid  = 1'b1;
              res_status = ST_ACK;
            end else if (c == CH_NAK) begin
              res_valid  = 1'b1;
              res_status = ST_NAK;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      bcc_r   <= '0;
      mnem_r  <= '0;
      mant_r  <= '0;
      dig_r   <= '0;
      plc_r   <= '0;
      point_r <= 1'b0;
      neg_r   <= 1'b0;
      bad_r   <= 1'b0;
      lead_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      bcc_r   <= bcc_nxt;
      mnem_r  <= mnem_nxt;
      mant_r  <= mant_nxt;
      dig_r   <= dig_nxt;
      plc_r   <= plc_nxt;
      point_r <= point_nxt;
      neg_r   <= neg_nxt;
      bad_r   <= bad_nxt;
      lead_r  <= lead_nxt;
    end
  end

  // Output register: refill whenever it is empty or being drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      out_status_r <= res_status;
      out_idx_r    <= res_idx;
      out_mant_r   <= res_mant;
      out_plc_r    <= res_plc;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.param_index    = out_idx_r;
  assign out_ch.value_mantissa = $signed(out_mant_r);
  assign out_ch.decimal_places = out_plc_r;

endmodule

// ===== sv/bcc_mnem_lookup.sv =====
// Mnemonic to parameter index lookup over the constant table.
module bcc_mnem_lookup
  import bcc_pkg::*;
(
  input  mnem_t mnem,
  output idx_t  index
);

  always_comb begin
    index = IDX_UNKNOWN;
    for (int i = MNEM_CNT - 1; i >= 0; i--) begin
      if (mnem == MNEM_TABLE[i]) begin
        index = IDX_W'(i);
      end
    end
  end

endmodule
